/* src/lane_voice_allocator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Lane voice allocator assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LANE_VOICE_ALLOCATOR_UNIT_ASSERT_SVH
`define LANE_VOICE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property that holds at every clock edge outside reset
`define LVA_ASSERT_HOLD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent that holds in the cycle after the antecedent
`define LVA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LVA_ASSERT_HOLD(label, clk, rst, prop, msg)
`define LVA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* src/lva_pkg.sv */
// ----------------------------------------------------------------------------
// Lane voice allocator package
// Sizes, codes, payload and control types shared by the allocator files.
// ----------------------------------------------------------------------------
package lva_pkg;

   // table sizes
   localparam int MAX_VOICES = 8;
   localparam int LANES      = 16;
   localparam int SLOT_W     = $clog2(MAX_VOICES);
   localparam int MAP_IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;

   // field widths
   localparam int OPCODE_W = 2;
   localparam int LANE_W   = 4;
   localparam int NOTE_W   = 7;
   localparam int COLOR_W  = 4;
   localparam int VEL_W    = 7;
   localparam int CHAN_W   = 5;
   localparam int VOICE_W  = 3;
   localparam int ORDER_W  = 32;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_END   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ALL   = 2'd2;

   // result event kinds
   localparam logic EV_NOTE_ON  = 1'b0;
   localparam logic EV_NOTE_OFF = 1'b1;

   // slot pointer selects
   localparam logic [2:0] IDX_HOLD = 3'd0;
   localparam logic [2:0] IDX_ZERO = 3'd1;
   localparam logic [2:0] IDX_INC  = 3'd2;
   localparam logic [2:0] IDX_MAP  = 3'd3;
   localparam logic [2:0] IDX_FREE = 3'd4;
   localparam logic [2:0] IDX_BEST = 3'd5;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [LANE_W-1:0]   lane_id;
      logic [NOTE_W-1:0]   midi_note;
      logic [COLOR_W-1:0]  color_index;
      logic [VEL_W-1:0]    velocity;
      logic                legato;
   } req_payload_type;

   typedef struct packed {
      logic                event_kind;
      logic [CHAN_W-1:0]   channel;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    out_velocity;
      logic [VOICE_W-1:0]  voice_slot;
      logic                last;
   } rsp_payload_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       take;
      logic [2:0] idx_sel;
      logic       scan_step;
      logic       claim;
      logic       trigger;
      logic       sound;
      logic       release_slot;
      logic       kill_slot;
      logic       clear_map;
      logic       emit_on;
      logic       emit_off_req;
      logic       emit_off_slot;
      logic       emit_last;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                in_range;
      logic                map_hit;
      logic                prefer_hit;
      logic                has_free;
      logic                idx_last;
      logic                sounding;
      logic                later_sounding;
      logic                glide;
      logic                out_free;
   } status_type;

   // map entry index of a lane
   function automatic logic [MAP_IDX_W-1:0] map_index(input logic [LANE_W-1:0] lane);
      map_index = MAP_IDX_W'(lane);
   endfunction

   // MIDI channel of a colour index
   function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color);
      chan_of = CHAN_W'(color) + CHAN_W'(1);
   endfunction

endpackage

/* src/lva_stream_if.sv */
// ----------------------------------------------------------------------------
// Lane voice allocator channels
// Valid/ready channels for request and response transfers.
// ----------------------------------------------------------------------------
interface lva_req_if;
   logic                     valid;
   logic                     ready;
   lva_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lva_rsp_if;
   logic                     valid;
   logic                     ready;
   lva_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/lva_ctrl.sv */
// ----------------------------------------------------------------------------
// Lane voice allocator controller
// Sequences decode, slot scans, allocation and result transfers per request.
// ----------------------------------------------------------------------------
`include "lane_voice_allocator_unit_assert.svh"

module lva_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lva_pkg::status_type status,
   output lva_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_ALL    = 4'd2;
   localparam logic [3:0] ST_END    = 4'd3;
   localparam logic [3:0] ST_SCAN   = 4'd4;
   localparam logic [3:0] ST_PICK   = 4'd5;
   localparam logic [3:0] ST_ASSIGN = 4'd6;
   localparam logic [3:0] ST_ON     = 4'd7;
   localparam logic [3:0] ST_OFF    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       emit_any;

   assign req_ready = (state_ff == ST_IDLE);
   assign emit_any  = cmd.emit_on | cmd.emit_off_req | cmd.emit_off_slot;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.idx_sel = lva_pkg::IDX_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.opcode)
               lva_pkg::OP_ALL: begin
                  cmd.idx_sel = lva_pkg::IDX_ZERO;
                  state_in    = ST_ALL;
               end
               lva_pkg::OP_START: begin
                  if (!status.in_range) begin
                     state_in = ST_IDLE;
                  end else if (status.prefer_hit) begin
                     cmd.idx_sel = lva_pkg::IDX_MAP;
                     state_in    = ST_ON;
                  end else if (status.has_free) begin
                     cmd.idx_sel = lva_pkg::IDX_FREE;
                     state_in    = ST_ASSIGN;
                  end else begin
                     cmd.idx_sel = lva_pkg::IDX_ZERO;
                     state_in    = ST_SCAN;
                  end
               end
               lva_pkg::OP_END: begin
                  if (status.in_range && status.map_hit) begin
                     cmd.idx_sel = lva_pkg::IDX_MAP;
                     state_in    = ST_END;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_END: begin
            if (!status.sounding) begin
               cmd.release_slot = 1'b1;
               state_in         = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit_off_req = 1'b1;
               cmd.emit_last    = 1'b1;
               cmd.release_slot = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_ALL: begin
            if (!status.sounding || status.out_free) begin
               cmd.emit_off_slot = status.sounding;
               cmd.emit_last     = !status.later_sounding;
               cmd.kill_slot     = 1'b1;
               if (status.idx_last) begin
                  cmd.clear_map = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.idx_sel = lva_pkg::IDX_INC;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_PICK;
            end else begin
               cmd.idx_sel = lva_pkg::IDX_INC;
            end
         end
         ST_PICK: begin
            cmd.idx_sel = lva_pkg::IDX_BEST;
            state_in    = ST_ASSIGN;
         end
         ST_ASSIGN: begin
            cmd.claim = 1'b1;
            state_in  = ST_ON;
         end
         ST_ON: begin
            if (status.out_free) begin
               cmd.emit_on   = 1'b1;
               cmd.trigger   = 1'b1;
               cmd.emit_last = !status.glide;
               if (status.glide) begin
                  state_in = ST_OFF;
               end else begin
                  cmd.sound = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_OFF: begin
            if (status.out_free) begin
               cmd.emit_off_req = 1'b1;
               cmd.emit_last    = 1'b1;
               cmd.sound        = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LVA_ASSERT_HOLD(a_emit_needs_room, clock, reset, !emit_any || status.out_free, "transfer loaded while output busy")
   `LVA_ASSERT_NEXT(a_pick_then_assign, clock, reset, state_ff == ST_PICK, state_ff == ST_ASSIGN, "steal pick not followed by assign")

endmodule

/* src/lva_datapath.sv */
// ----------------------------------------------------------------------------
// Lane voice allocator datapath
// Voice table, lane map, oldest-trigger scan and the response register.
// ----------------------------------------------------------------------------
`include "lane_voice_allocator_unit_assert.svh"

module lva_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  lva_pkg::req_payload_type req_payload,
   input  lva_pkg::cmd_type         cmd,
   output lva_pkg::status_type      status,
   output logic                     rsp_valid,
   output lva_pkg::rsp_payload_type rsp_payload,
   input  logic                     rsp_ready
);

   localparam logic [lva_pkg::SLOT_W-1:0] SLOT_LAST = lva_pkg::SLOT_W'(lva_pkg::MAX_VOICES - 1);

   // latched request
   lva_pkg::req_payload_type req_ff;

   // voice table
   logic [lva_pkg::MAX_VOICES-1:0]  lane_ok_ff;
   logic [lva_pkg::MAX_VOICES-1:0]  note_ok_ff;
   logic [lva_pkg::LANE_W-1:0]      slot_lane_ff  [lva_pkg::MAX_VOICES];
   logic [lva_pkg::NOTE_W-1:0]      slot_note_ff  [lva_pkg::MAX_VOICES];
   logic [lva_pkg::COLOR_W-1:0]     slot_color_ff [lva_pkg::MAX_VOICES];
   logic [lva_pkg::ORDER_W-1:0]     slot_order_ff [lva_pkg::MAX_VOICES];
   logic [lva_pkg::ORDER_W-1:0]     trigger_count_ff;
   logic [lva_pkg::ORDER_W-1:0]     trigger_count_in;

   // lane map
   logic [lva_pkg::LANES-1:0]       map_ok_ff;
   logic [lva_pkg::SLOT_W-1:0]      map_slot_ff [lva_pkg::LANES];

   // slot pointer and scan
   logic [lva_pkg::SLOT_W-1:0]      idx_ff;
   logic [lva_pkg::SLOT_W-1:0]      idx_in;
   logic [lva_pkg::SLOT_W-1:0]      best_slot_ff;
   logic [lva_pkg::ORDER_W-1:0]     best_order_ff;
   logic [lva_pkg::SLOT_W-1:0]      free_slot;

   // response register
   logic                            rsp_valid_ff;
   lva_pkg::rsp_payload_type        rsp_ff;
   logic                            out_free;

   logic [lva_pkg::MAP_IDX_W-1:0]   req_map_idx;
   logic [lva_pkg::MAP_IDX_W-1:0]   own_map_idx;
   logic [lva_pkg::MAX_VOICES-1:0]  above_mask;

   assign req_map_idx      = lva_pkg::map_index(req_ff.lane_id);
   assign own_map_idx      = lva_pkg::map_index(slot_lane_ff[idx_ff]);
   assign out_free         = !rsp_valid_ff || rsp_ready;
   assign trigger_count_in = trigger_count_ff + lva_pkg::ORDER_W'(1);

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = lva_pkg::MAX_VOICES - 1; i >= 0; i--) begin
         if (!lane_ok_ff[i]) begin
            free_slot = lva_pkg::SLOT_W'(i);
         end
      end
   end

   // slots above the pointer
   always_comb begin
      for (int i = 0; i < lva_pkg::MAX_VOICES; i++) begin
         above_mask[i] = (lva_pkg::SLOT_W'(i) > idx_ff);
      end
   end

   // status toward the controller
   always_comb begin
      status.opcode         = req_ff.opcode;
      status.in_range       = (32'(req_ff.lane_id) < 32'(lva_pkg::LANES));
      status.map_hit        = map_ok_ff[req_map_idx];
      status.prefer_hit     = req_ff.legato && map_ok_ff[req_map_idx];
      status.has_free       = !(&lane_ok_ff);
      status.idx_last       = (idx_ff == SLOT_LAST);
      status.sounding       = note_ok_ff[idx_ff];
      status.later_sounding = |(note_ok_ff & above_mask);
      status.glide          = req_ff.legato && note_ok_ff[idx_ff]
                              && (slot_note_ff[idx_ff] != req_ff.midi_note);
      status.out_free       = out_free;
   end

   // slot pointer select
   always_comb begin
      case (cmd.idx_sel)
         lva_pkg::IDX_ZERO: idx_in = '0;
         lva_pkg::IDX_INC:  idx_in = idx_ff + lva_pkg::SLOT_W'(1);
         lva_pkg::IDX_MAP:  idx_in = map_slot_ff[req_map_idx];
         lva_pkg::IDX_FREE: idx_in = free_slot;
         lva_pkg::IDX_BEST: idx_in = best_slot_ff;
         default:           idx_in = idx_ff;
      endcase
   end

   // control state: valid bits, orders, colours, count, slot pointer, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ok_ff       <= '0;
         note_ok_ff       <= '0;
         map_ok_ff        <= '0;
         trigger_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
         idx_ff           <= '0;
         for (int i = 0; i < lva_pkg::MAX_VOICES; i++) begin
            slot_order_ff[i] <= '0;
            slot_color_ff[i] <= '0;
         end
      end else begin
         idx_ff <= idx_in;
         // claim a slot; a stolen slot drops its old lane's entry
         if (cmd.claim) begin
            if (lane_ok_ff[idx_ff]) begin
               map_ok_ff[own_map_idx] <= 1'b0;
            end
            lane_ok_ff[idx_ff]     <= 1'b1;
            map_ok_ff[req_map_idx] <= 1'b1;
         end
         if (cmd.trigger) begin
            trigger_count_ff      <= trigger_count_in;
            slot_order_ff[idx_ff] <= trigger_count_in;
            slot_color_ff[idx_ff] <= req_ff.color_index;
         end
         if (cmd.sound) begin
            note_ok_ff[idx_ff] <= 1'b1;
         end
         if (cmd.release_slot) begin
            note_ok_ff[idx_ff]     <= 1'b0;
            lane_ok_ff[idx_ff]     <= 1'b0;
            map_ok_ff[req_map_idx] <= 1'b0;
         end
         if (cmd.kill_slot) begin
            note_ok_ff[idx_ff] <= 1'b0;
            lane_ok_ff[idx_ff] <= 1'b0;
         end
         if (cmd.clear_map) begin
            map_ok_ff <= '0;
         end
         // hold the response until its transfer
         if (cmd.emit_on || cmd.emit_off_req || cmd.emit_off_slot) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         req_ff <= req_payload;
      end
      if (cmd.claim) begin
         slot_lane_ff[idx_ff]     <= req_ff.lane_id;
         map_slot_ff[req_map_idx] <= idx_ff;
      end
      if (cmd.sound) begin
         slot_note_ff[idx_ff] <= req_ff.midi_note;
      end
      // keep the oldest trigger order seen so far; ties stay on the lower slot
      if (cmd.scan_step) begin
         if ((idx_ff == '0) || (slot_order_ff[idx_ff] < best_order_ff)) begin
            best_order_ff <= slot_order_ff[idx_ff];
            best_slot_ff  <= idx_ff;
         end
      end
      // load the response
      if (cmd.emit_on) begin
         rsp_ff.event_kind   <= lva_pkg::EV_NOTE_ON;
         rsp_ff.channel      <= lva_pkg::chan_of(req_ff.color_index);
         rsp_ff.note         <= req_ff.midi_note;
         rsp_ff.out_velocity <= req_ff.velocity;
         rsp_ff.voice_slot   <= lva_pkg::VOICE_W'(idx_ff);
         rsp_ff.last         <= cmd.emit_last;
      end else if (cmd.emit_off_req || cmd.emit_off_slot) begin
         rsp_ff.event_kind   <= lva_pkg::EV_NOTE_OFF;
         rsp_ff.channel      <= cmd.emit_off_slot ? lva_pkg::chan_of(slot_color_ff[idx_ff])
                                                  : lva_pkg::chan_of(req_ff.color_index);
         rsp_ff.note         <= slot_note_ff[idx_ff];
         rsp_ff.out_velocity <= '0;
         rsp_ff.voice_slot   <= lva_pkg::VOICE_W'(idx_ff);
         rsp_ff.last         <= cmd.emit_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `LVA_ASSERT_HOLD(a_sounding_has_lane, clock, reset, (note_ok_ff & ~lane_ok_ff) == '0, "sounding slot without lane")
   `LVA_ASSERT_NEXT(a_claim_maps_lane, clock, reset, cmd.claim, map_ok_ff[$past(req_map_idx)] && (map_slot_ff[$past(req_map_idx)] == $past(idx_ff)), "claimed slot not mapped to lane")

endmodule

/* src/lane_voice_allocator_unit.v.sv */
// ----------------------------------------------------------------------------
// Lane voice allocator unit
// Voice allocation for drawing lanes with oldest-trigger stealing.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                      handshake
//  req_bus   in         opcode, lane_id, midi_note, color, vel, leg  valid/ready
//  rsp_bus   out        event_kind, channel, note, velocity, slot    valid/ready
//
//  One request at a time: a reserved code or a note end on an unmapped lane
//  ends at decode; a note end on a mapped lane releases its voice; a start
//  claims a free voice, or scans every slot (one trigger-order compare per slot)
//  to steal, unless it holds its lane's voice; all notes off visits every slot.
//  Each result waits for room in the output register.
//  Reset (synchronous) clears valid bits, orders, colours and the count at once.
//  A result waits in the output register while the next request is taken.
module lane_voice_allocator_unit (
   input logic       clock,
   input logic       reset,
   lva_req_if.sink   req_bus,
   lva_rsp_if.source rsp_bus
);

   lva_pkg::cmd_type    cmd;
   lva_pkg::status_type status;

   // sequence each request
   lva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // tables and response register
   lva_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_bus.payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_bus.valid),
      .rsp_payload (rsp_bus.payload),
      .rsp_ready   (rsp_bus.ready)
   );

endmodule

/* test/lane_voice_allocator_unit_checker.sv */
// ----------------------------------------------------------------------------
// Lane voice allocator checker
// Watches the request and response channels. Each request transfer runs
// through a local model of the voice table, and the model's MIDI events queue
// up. Each response transfer is compared field by field with the oldest
// queued event.
// ----------------------------------------------------------------------------
module lane_voice_allocator_unit_checker (
   input  logic clock,
   input  logic reset,
   lva_req_if   req_mon,
   lva_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   events_pending,
   output int   requests_seen,
   output int   events_seen,
   output int   steal_count,
   output int   glide_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // voice table and lane map of the model
   logic [lva_pkg::LANE_W-1:0]  voice_lane     [lva_pkg::MAX_VOICES];
   logic                        voice_owned    [lva_pkg::MAX_VOICES];
   logic [lva_pkg::NOTE_W-1:0]  voice_note     [lva_pkg::MAX_VOICES];
   logic                        voice_sounding [lva_pkg::MAX_VOICES];
   logic [lva_pkg::COLOR_W-1:0] voice_color    [lva_pkg::MAX_VOICES];
   logic [lva_pkg::ORDER_W-1:0] voice_age      [lva_pkg::MAX_VOICES];
   logic [lva_pkg::ORDER_W-1:0] trigger_total;
   logic [lva_pkg::VOICE_W-1:0] lane_voice     [lva_pkg::LANES];
   logic                        lane_bound     [lva_pkg::LANES];

   // MIDI events predicted but not yet seen on the response channel
   lva_pkg::rsp_payload_type expected_events[$];
   lva_pkg::rsp_payload_type want_event;

   int mismatches;
   int requests;
   int events;
   int steals;
   int glides;

   function automatic lva_pkg::rsp_payload_type midi_event(
         input logic                        kind,
         input logic [lva_pkg::CHAN_W-1:0]  chan,
         input logic [lva_pkg::NOTE_W-1:0]  note,
         input logic [lva_pkg::VEL_W-1:0]   vel,
         input logic [lva_pkg::VOICE_W-1:0] slot);
      lva_pkg::rsp_payload_type ev;
      ev.event_kind   = kind;
      ev.channel      = chan;
      ev.note         = note;
      ev.out_velocity = vel;
      ev.voice_slot   = slot;
      ev.last         = 1'b0;
      return ev;
   endfunction

   // Choose the voice of a start: the lane's own voice on legato, else the
   // lowest free slot, else the slot triggered longest ago.
   task automatic pick_voice_slot(input logic [lva_pkg::LANE_W-1:0] lane,
                                  input logic keep_lane,
                                  output logic [lva_pkg::VOICE_W-1:0] slot,
                                  output logic stolen);
      logic [lva_pkg::ORDER_W-1:0] oldest;
      logic found;
      int i;
      slot   = '0;
      stolen = 1'b0;
      found  = 1'b0;
      if (keep_lane && lane_bound[lane]) begin
         slot = lane_voice[lane];
      end else begin
         for (i = 0; i < lva_pkg::MAX_VOICES; i++) begin
            if (!found && !voice_owned[i]) begin
               slot  = lva_pkg::VOICE_W'(i);
               found = 1'b1;
            end
         end
         if (!found) begin
            // steal: strictly older wins, ties stay with the lower slot
            oldest = voice_age[0];
            for (i = 1; i < lva_pkg::MAX_VOICES; i++) begin
               if (voice_age[i] < oldest) begin
                  oldest = voice_age[i];
                  slot   = lva_pkg::VOICE_W'(i);
               end
            end
            // the previous owner loses its map entry wherever it points
            if (voice_owned[slot]) begin
               lane_bound[voice_lane[slot]] = 1'b0;
            end
            stolen = 1'b1;
         end
         voice_owned[slot] = 1'b1;
         voice_lane[slot]  = lane;
         lane_voice[lane]  = slot;
         lane_bound[lane]  = 1'b1;
      end
   endtask

   // Advance the model by one request and queue the events it causes.
   task automatic play_request(input lva_pkg::req_payload_type r);
      lva_pkg::rsp_payload_type    burst[$];
      logic [lva_pkg::VOICE_W-1:0] slot;
      logic [lva_pkg::CHAN_W-1:0]  chan;
      logic                        stolen;
      logic                        glide;
      int                          i;
      chan = lva_pkg::CHAN_W'(r.color_index) + lva_pkg::CHAN_W'(1);
      case (r.opcode)
         lva_pkg::OP_START: begin
            pick_voice_slot(r.lane_id, r.legato, slot, stolen);
            glide = r.legato && voice_sounding[slot];
            trigger_total     = trigger_total + lva_pkg::ORDER_W'(1);
            voice_age[slot]   = trigger_total;
            voice_color[slot] = r.color_index;
            burst = {burst, midi_event(lva_pkg::EV_NOTE_ON, chan, r.midi_note,
                                       r.velocity, slot)};
            // glide handover: release the old note after the new one starts
            if (glide && voice_note[slot] != r.midi_note) begin
               burst = {burst, midi_event(lva_pkg::EV_NOTE_OFF, chan, voice_note[slot],
                                          '0, slot)};
               glides++;
            end
            voice_note[slot]     = r.midi_note;
            voice_sounding[slot] = 1'b1;
            if (stolen) begin
               steals++;
            end
         end
         lva_pkg::OP_END: begin
            if (lane_bound[r.lane_id]) begin
               slot = lane_voice[r.lane_id];
               if (voice_sounding[slot]) begin
                  burst = {burst, midi_event(lva_pkg::EV_NOTE_OFF, chan, voice_note[slot],
                                             '0, slot)};
               end
               voice_sounding[slot]   = 1'b0;
               voice_owned[slot]      = 1'b0;
               lane_bound[r.lane_id] = 1'b0;
            end
         end
         lva_pkg::OP_ALL: begin
            for (i = 0; i < lva_pkg::MAX_VOICES; i++) begin
               if (voice_sounding[i]) begin
                  burst = {burst, midi_event(lva_pkg::EV_NOTE_OFF,
                                             lva_pkg::CHAN_W'(voice_color[i])
                                                + lva_pkg::CHAN_W'(1),
                                             voice_note[i], '0, lva_pkg::VOICE_W'(i))};
               end
               voice_sounding[i] = 1'b0;
               voice_owned[i]    = 1'b0;
            end
            for (i = 0; i < lva_pkg::LANES; i++) begin
               lane_bound[i] = 1'b0;
            end
         end
         default: begin
            // reserved opcode: no effect
         end
      endcase
      // flag the final event of this request
      if (burst.size() > 0) begin
         burst[burst.size() - 1].last = 1'b1;
      end
      expected_events = {expected_events, burst};
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Predict on request transfers, compare on response transfers.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lva_pkg::MAX_VOICES; i++) begin
            voice_lane[i]     = '0;
            voice_owned[i]    = 1'b0;
            voice_note[i]     = '0;
            voice_sounding[i] = 1'b0;
            voice_color[i]    = '0;
            voice_age[i]      = '0;
         end
         for (int i = 0; i < lva_pkg::LANES; i++) begin
            lane_voice[i] = '0;
            lane_bound[i] = 1'b0;
         end
         trigger_total = '0;
         expected_events.delete();
         mismatches = 0;
         requests   = 0;
         events     = 0;
         steals     = 0;
         glides     = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            play_request(req_mon.payload);
            requests++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            events++;
            if (expected_events.size() == 0) begin
               $error("MIDI event with nothing predicted: kind %0d channel %0d note %0d",
                      rsp_mon.payload.event_kind, rsp_mon.payload.channel,
                      rsp_mon.payload.note);
               mismatches++;
            end else begin
               want_event = expected_events.pop_front();
               check_field("event_kind", int'(want_event.event_kind),
                           int'(rsp_mon.payload.event_kind));
               check_field("channel", int'(want_event.channel),
                           int'(rsp_mon.payload.channel));
               check_field("note", int'(want_event.note), int'(rsp_mon.payload.note));
               check_field("out_velocity", int'(want_event.out_velocity),
                           int'(rsp_mon.payload.out_velocity));
               check_field("voice_slot", int'(want_event.voice_slot),
                           int'(rsp_mon.payload.voice_slot));
               check_field("last", int'(want_event.last), int'(rsp_mon.payload.last));
            end
         end
      end
      mismatch_count <= mismatches;
      events_pending <= expected_events.size();
      requests_seen  <= requests;
      events_seen    <= events;
      steal_count    <= steals;
      glide_count    <= glides;
   end

endmodule

/* test/lane_voice_allocator_unit_tb.sv */
// ----------------------------------------------------------------------------
// Lane voice allocator testbench
// Drives note start, note end and all-notes-off requests into the allocator:
// first a directed sequence through free voices, legato glides, steals and a
// full all-notes-off, then random traffic under several idle and stall mixes
// and one long receiver hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module lane_voice_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 8;
   localparam int RESET_CYCLES    = 11;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int TAIL_CYCLES     = 60;
   localparam int PHASE_ITEMS     = 30;
   localparam int PRESSURE_ITEMS  = 25;

   // opcode that the block ignores
   localparam logic [lva_pkg::OPCODE_W-1:0] OP_RESERVED = 2'd3;

   logic clock = 1'b0;
   logic reset;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic hold_off_go = 1'b0;
   logic hold_done   = 1'b0;
   int idle_cycles   = 0;

   int mismatch_count;
   int events_pending;
   int requests_seen;
   int events_seen;
   int steal_count;
   int glide_count;

   lva_req_if req_bus();
   lva_rsp_if rsp_bus();

   always #(CLK_PERIOD / 2) clock = ~clock;

   lane_voice_allocator_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   lane_voice_allocator_unit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .events_pending (events_pending),
      .requests_seen  (requests_seen),
      .events_seen    (events_seen),
      .steal_count    (steal_count),
      .glide_count    (glide_count)
   );

   function automatic lva_pkg::req_payload_type make_request(
         input logic [lva_pkg::OPCODE_W-1:0] op,
         input int lane, input int note,
         input int color, input int vel,
         input logic leg);
      lva_pkg::req_payload_type r;
      r.opcode      = op;
      r.lane_id     = lva_pkg::LANE_W'(lane);
      r.midi_note   = lva_pkg::NOTE_W'(note);
      r.color_index = lva_pkg::COLOR_W'(color);
      r.velocity    = lva_pkg::VEL_W'(vel);
      r.legato      = leg;
      return r;
   endfunction

   // Mostly starts and ends on a few busy lanes, so that lanes hold voices,
   // ends find them and the table fills up; some all-off and reserved codes.
   function automatic lva_pkg::req_payload_type random_request();
      logic [lva_pkg::OPCODE_W-1:0] op;
      int pick;
      int lane;
      pick = $urandom_range(99);
      if (pick < 55) begin
         op = lva_pkg::OP_START;
      end else if (pick < 88) begin
         op = lva_pkg::OP_END;
      end else if (pick < 95) begin
         op = lva_pkg::OP_ALL;
      end else begin
         op = OP_RESERVED;
      end
      lane = ($urandom_range(99) < 70) ? $urandom_range(5)
                                       : $urandom_range(lva_pkg::LANES - 1);
      return make_request(op, lane, $urandom_range(127), $urandom_range(15),
                          $urandom_range(127), 1'($urandom_range(1)));
   endfunction

   // Offer one request after a random gap and hold it until the transfer.
   task automatic send_item(input lva_pkg::req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      lva_pkg::req_payload_type item;
      int sent;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         item = random_request();
         send_item(item);
         if (item.opcode != OP_RESERVED) begin
            sent++;
         end
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request.
   initial begin : rsp_drain
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Stop the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d events outstanding",
                  idle_cycles, events_pending);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty table: end without voice, all-off with nothing sounding, reserved code
      send_item(make_request(lva_pkg::OP_END, 0, 10, 0, 10, 1'b0));
      send_item(make_request(lva_pkg::OP_ALL, 15, 127, 15, 127, 1'b1));
      send_item(make_request(OP_RESERVED, 9, 127, 15, 127, 1'b1));
      // field extremes on free voices
      send_item(make_request(lva_pkg::OP_START, 0, 0, 0, 0, 1'b0));
      send_item(make_request(lva_pkg::OP_START, 15, 127, 15, 127, 1'b0));
      // legato on the same note, then legato to a new note (glide pair)
      send_item(make_request(lva_pkg::OP_START, 0, 0, 3, 64, 1'b1));
      send_item(make_request(lva_pkg::OP_START, 0, 64, 7, 100, 1'b1));
      // legato on a lane without a voice
      send_item(make_request(lva_pkg::OP_START, 3, 60, 1, 80, 1'b1));
      // plain start on a lane that already holds a voice
      send_item(make_request(lva_pkg::OP_START, 0, 62, 2, 90, 1'b0));
      // fill the remaining voices
      for (int i = 4; i < 8; i++) begin
         send_item(make_request(lva_pkg::OP_START, i, 36 + i, i, 20 + i, 1'b0));
      end
      // full table: plain steal, then legato steal of a sounding voice
      send_item(make_request(lva_pkg::OP_START, 8, 50, 8, 70, 1'b0));
      send_item(make_request(lva_pkg::OP_START, 9, 51, 9, 71, 1'b1));
      // end on a lane whose voice was stolen, then on lane 0, unmapped by the legato steal
      send_item(make_request(lva_pkg::OP_END, 15, 0, 0, 0, 1'b0));
      send_item(make_request(lva_pkg::OP_END, 0, 0, 12, 0, 1'b1));
      send_item(make_request(lva_pkg::OP_START, 0, 100, 4, 33, 1'b1));
      send_item(make_request(lva_pkg::OP_END, 4, 0, 5, 0, 1'b0));
      send_item(make_request(lva_pkg::OP_START, 10, 90, 13, 99, 1'b0));
      // all notes off with every voice sounding
      send_item(make_request(lva_pkg::OP_ALL, 0, 0, 0, 0, 1'b0));
      send_item(make_request(lva_pkg::OP_START, 2, 127, 15, 127, 1'b1));
      send_item(make_request(lva_pkg::OP_END, 2, 5, 0, 5, 1'b0));

      // random traffic under each idle mix
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(81, 0, PHASE_ITEMS);
      run_phase(0, 81, PHASE_ITEMS);
      run_phase(27, 27, PHASE_ITEMS);
      // keep offering while the receiver holds off
      hold_off_go = 1'b1;
      run_phase(0, 0, PRESSURE_ITEMS);
      req_bus.valid <= 1'b0;
      rsp_stall_pct = 0;

      // drain the predicted events, then let the block settle
      @(posedge clock);
      while (events_pending != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d MIDI events, with %0d voice steals",
               requests_seen, events_seen, steal_count);
      $display("and %0d legato glide pairs, under idle, stall and hold-off mixes",
               glide_count);
      if (mismatch_count == 0 && events_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/lva_pkg.sv
src/lva_stream_if.sv
src/lva_ctrl.sv
src/lva_datapath.sv
src/lane_voice_allocator_unit.v.sv
test/lane_voice_allocator_unit_checker.sv
test/lane_voice_allocator_unit_tb.sv
